### design/spd_pkg.sv
`default_nettype none

package spd_pkg;

    localparam int MAX_LENGTH  = 16;
    localparam int SYMBOL_BITS = 8;
    localparam int PAT_WORDS   = 4;
    localparam int PAT_SYMBOLS = 4 * PAT_WORDS;
    localparam int LEN_W       = $clog2(MAX_LENGTH + 1);
    localparam int SEQ_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic [SYMBOL_BITS-1:0] t_sym;
    typedef logic [CFG_DATA_W-1:0]  t_word;
    typedef logic [LEN_W-1:0]       t_len;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEQ_LENGTH = 3'd0,
        CFG_PATTERN0   = 3'd1,
        CFG_PATTERN1   = 3'd2,
        CFG_PATTERN2   = 3'd3,
        CFG_PATTERN3   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic active;
        t_sym pattern;
    } t_cell_ctl;

    // Pattern symbols beyond the four configuration words read as zero.
    function automatic t_sym pattern_symbol(input t_word words [PAT_WORDS], input t_len idx);
        t_sym sym;
        sym = '0;
        if (int'(idx) < PAT_SYMBOLS) begin
            sym = words[idx[3:2]][{idx[1:0], 3'b000} +: SYMBOL_BITS];
        end
        return sym;
    endfunction

endpackage

`default_nettype wire

### design/spd_cell.sv
`default_nettype none

module spd_cell
    import spd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_sym      i_sym,
    output t_sym           o_sym,
    output logic           o_hit
);

    t_sym r_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= '0;
        end else if (i_ctl.shift) begin
            r_sym <= i_sym;
        end
    end

    assign o_sym = r_sym;
    assign o_hit = !i_ctl.active || (i_sym == i_ctl.pattern);

endmodule

`default_nettype wire

### design/sync_pattern_detector.sv
// Sync word detector. Each accepted request carries one symbol, which enters a
// chain of MAX_LENGTH symbol cells; every cell compares the symbol arriving at
// it with its pattern symbol, so the newest seq_length symbols are checked in
// the cycle the request is accepted and one result per request is registered
// for the output. The detector accepts one symbol per clock cycle unless
// o_in_stall is high. Results are registered into a two-entry output buffer
// that keeps the input open while a result waits; the chain compare and its
// AND reduction are combinational. A match clears the fill count, so the next
// match needs seq_length new symbols. Writing seq_length also clears it.
`default_nettype none

module sync_pattern_detector
    import spd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_symbol,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_match,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SEQ_W-1:0] r_seq_length;
    t_word            r_pattern [PAT_WORDS];
    t_len             r_fill;
    t_len             n_fill;
    t_len             active_len;
    logic             r_ov;
    logic             r_omatch;
    logic             r_sv;
    logic             r_smatch;
    logic             n_ov;
    logic             n_omatch;
    logic             n_sv;
    logic             n_smatch;
    logic             in_fire;
    logic             out_fire;
    logic             hit;
    logic             full;
    t_len             fill_inc;
    t_sym             chain_sym [MAX_LENGTH+1];
    logic [MAX_LENGTH-1:0] cell_hit;

    assign in_fire  = i_in_valid && !r_sv;
    assign out_fire = r_ov && !i_out_stall;

    always_comb begin
        if (r_seq_length == '0) begin
            active_len = t_len'(1);
        end else if (int'(r_seq_length) > MAX_LENGTH) begin
            active_len = t_len'(MAX_LENGTH);
        end else begin
            active_len = t_len'(r_seq_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_length <= SEQ_W'(16);
            for (int k = 0; k < PAT_WORDS; k++) begin
                r_pattern[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEQ_LENGTH: r_seq_length <= i_cfg_data[SEQ_W-1:0];
                CFG_PATTERN0:   r_pattern[0] <= i_cfg_data;
                CFG_PATTERN1:   r_pattern[1] <= i_cfg_data;
                CFG_PATTERN2:   r_pattern[2] <= i_cfg_data;
                CFG_PATTERN3:   r_pattern[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign chain_sym[0] = i_symbol[SYMBOL_BITS-1:0];

    for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_cell
        t_cell_ctl ctl;
        t_len      pidx;

        assign pidx       = t_len'(active_len - t_len'(1) - t_len'(g));
        assign ctl.shift  = in_fire;
        assign ctl.active = t_len'(g) < active_len;
        assign ctl.pattern = pattern_symbol(r_pattern, pidx);

        spd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_sym   (chain_sym[g]),
            .o_sym   (chain_sym[g+1]),
            .o_hit   (cell_hit[g])
        );
    end

    assign fill_inc = (r_fill < active_len) ? t_len'(r_fill + t_len'(1)) : r_fill;
    assign full     = fill_inc >= active_len;
    assign hit      = full && (&cell_hit);

    always_comb begin
        n_fill = r_fill;
        if (i_cfg_we && i_cfg_index == CFG_SEQ_LENGTH) begin
            n_fill = '0;
        end else if (in_fire) begin
            n_fill = hit ? '0 : fill_inc;
        end
    end

    always_comb begin
        n_ov     = r_ov;
        n_omatch = r_omatch;
        n_sv     = r_sv;
        n_smatch = r_smatch;
        if (out_fire) begin
            if (r_sv) begin
                n_omatch = r_smatch;
                n_sv     = 1'b0;
            end else if (in_fire) begin
                n_omatch = hit;
            end else begin
                n_ov = 1'b0;
            end
        end else if (in_fire) begin
            if (!r_ov) begin
                n_ov     = 1'b1;
                n_omatch = hit;
            end else begin
                n_sv     = 1'b1;
                n_smatch = hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ov   <= 1'b0;
            r_sv   <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_ov   <= n_ov;
            r_sv   <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_omatch <= n_omatch;
        r_smatch <= n_smatch;
    end

    assign o_in_stall  = r_sv;
    assign o_out_valid = r_ov;
    assign o_match     = r_omatch;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held without an output entry");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= active_len)
        else $error("fill count above active length");

    a_hit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && hit |=> r_fill == '0)
        else $error("fill count not cleared after a match");

    a_hit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && hit |-> fill_inc == active_len)
        else $error("match reported before the window was full");

endmodule

`default_nettype wire

### tb/sv/sync_pattern_detector_tb.sv
module sync_pattern_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;

    class sync_window_tracker;
        logic [SEQ_W-1:0] seq_length;
        t_word            pattern_words [PAT_WORDS];
        t_sym             window [MAX_LENGTH];
        int               fill_count;
        bit               hit_q [$];
        int               errors;
        int               symbols;
        int               hits;
        int               writes;

        function new();
            seq_length = SEQ_W'(MAX_LENGTH);
            foreach (pattern_words[w]) pattern_words[w] = '0;
            foreach (window[i]) window[i] = '0;
            fill_count = 0;
            errors     = 0;
            symbols    = 0;
            hits       = 0;
            writes     = 0;
        endfunction

        function int active_len();
            if (seq_length == 0) return 1;
            if (int'(seq_length) > MAX_LENGTH) return MAX_LENGTH;
            return int'(seq_length);
        endfunction

        function t_sym pattern_at(int idx);
            if (idx >= PAT_SYMBOLS) return '0;
            return t_sym'(pattern_words[idx >> 2] >> (8 * (idx & 3)));
        endfunction

        function int pending();
            return hit_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_word data);
            writes++;
            case (t_cfg_idx'(idx))
                CFG_SEQ_LENGTH: begin
                    seq_length = data[SEQ_W-1:0];
                    fill_count = 0;
                end
                CFG_PATTERN0, CFG_PATTERN1, CFG_PATTERN2, CFG_PATTERN3: begin
                    pattern_words[int'(idx) - int'(CFG_PATTERN0)] = data;
                end
                default: ;
            endcase
        endfunction

        function void note_symbol(t_sym sym);
            int len;
            bit hit;
            len = active_len();
            for (int i = MAX_LENGTH - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = sym;
            if (fill_count < len) fill_count++;
            hit = 1'b0;
            if (fill_count >= len) begin
                hit = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (window[len-1-i] != pattern_at(i)) hit = 1'b0;
                end
                if (hit) fill_count = 0;
            end
            hit_q.push_back(hit);
            symbols++;
            if (hit) hits++;
        endfunction

        function void check_match(logic actual);
            bit expected;
            if (hit_q.size() == 0) begin
                $error("match: expected none, actual %0b", actual);
                errors++;
            end else begin
                expected = hit_q.pop_front();
                if (actual !== expected) begin
                    $error("match: expected %0b, actual %0b", expected, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_symbol    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_match;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    sync_window_tracker tracker;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  sent_count    = 0;
    int  settings      = 0;
    int  quiet_cycles  = 0;
    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    sync_pattern_detector i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.write_reg(i_cfg_index, i_cfg_data);
            if (in_fire) tracker.note_symbol(t_sym'(i_symbol));
            if (out_fire) tracker.check_match(o_match);
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out after %0d cycles without a request.", quiet_cycles);
            $display("FAIL sync_pattern_detector");
            $finish;
        end
    end

    // The receiver either stalls at random or, on request, holds off for a long stretch.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_symbol(input t_sym sym);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input t_word data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic reg_done();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_sym noise_symbol();
        if ($urandom_range(1) == 0) return t_sym'($urandom());
        return tracker.pattern_at($urandom_range(tracker.active_len() - 1));
    endfunction

    // Most frames carry the whole pattern after some noise; some are corrupted or pure noise.
    task automatic send_frame();
        int   len;
        int   lead;
        int   kind;
        int   bad;
        t_sym sym;
        len  = tracker.active_len();
        lead = $urandom_range(len / 2);
        kind = $urandom_range(9);
        bad  = (kind >= 7) ? $urandom_range(len - 1) : -1;
        for (int i = 0; i < lead; i++) send_symbol(noise_symbol());
        for (int i = 0; i < len; i++) begin
            sym = (kind == 9) ? noise_symbol() : tracker.pattern_at(i);
            if (i == bad) sym ^= t_sym'($urandom_range(1, (1 << SYMBOL_BITS) - 1));
            send_symbol(sym);
        end
    endtask

    task automatic new_setting();
        t_word len_word;
        t_word data;
        t_sym  fill;
        bit    uniform;
        int    len;
        case ($urandom_range(9))
            0: len = 1;
            1: len = MAX_LENGTH;
            2: len = 0;
            3: len = $urandom_range(MAX_LENGTH + 1, (1 << SEQ_W) - 1);
            default: len = $urandom_range(1, MAX_LENGTH);
        endcase
        len_word = $urandom();
        len_word[SEQ_W-1:0] = SEQ_W'(len);
        reg_write(CFG_SEQ_LENGTH, len_word);
        uniform = ($urandom_range(5) == 0);
        fill    = t_sym'($urandom());
        for (int w = 0; w < PAT_WORDS; w++) begin
            if (settings == 0 || $urandom_range(3) != 0) begin
                data = uniform ? {4{fill}} : t_word'($urandom());
                reg_write(CFG_IDX_W'(int'(CFG_PATTERN0) + w), data);
            end
        end
        reg_done();
        settings++;
    endtask

    task automatic run_stage(input int send_pct, input int recv_pct, input int item_goal,
                             input bit squeeze);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent_count < item_goal) begin
            new_setting();
            if (squeeze) begin
                hold_request = 1'b1;
                squeeze = 1'b0;
            end
            target = sent_count + $urandom_range(20, 60);
            while (sent_count < target) send_frame();
            drain();
        end
    endtask

    initial begin
        tracker = new();
        send_idle_pct = 23;
        recv_idle_pct = 74;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset pattern is all zero at full length, so a run of zeros must hit once.
        repeat (MAX_LENGTH) send_symbol('0);
        drain();

        // A length of zero acts as one, so every matching symbol hits on its own.
        reg_write(CFG_SEQ_LENGTH, '0);
        reg_write(CFG_PATTERN0, 32'h0000_00FF);
        reg_done();
        send_symbol(8'hFF);
        send_symbol(8'hFF);
        send_symbol(8'h00);
        drain();

        // Upper data bits of the length are ignored, and unmapped indexes leave the pattern.
        reg_write(CFG_SEQ_LENGTH, 32'hFFFF_FFE2);
        reg_write(CFG_PATTERN0, 32'h0000_807F);
        for (int k = int'(CFG_PATTERN3) + 1; k < (1 << CFG_IDX_W); k++) begin
            reg_write(CFG_IDX_W'(k), '1);
        end
        reg_done();
        send_symbol(8'h7F);
        send_symbol(8'h80);
        send_symbol(8'h7F);
        send_symbol(8'h80);
        send_symbol(8'h7F);
        drain();

        // Rewriting the length restarts the fill count, so the completed window must not hit.
        reg_write(CFG_SEQ_LENGTH, t_word'(2));
        reg_done();
        send_symbol(8'h80);
        drain();

        run_stage(23, 74, 650, 1'b0);
        run_stage(74, 23, 1300, 1'b0);
        run_stage(0, 0, 1900, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d symbols over %0d settings with %0d register writes.",
                 tracker.symbols, settings, tracker.writes);
        $display("Saw %0d sync hits with %0d mismatches.", tracker.hits, tracker.errors);
        if (tracker.errors == 0) begin
            $display("PASS sync_pattern_detector");
        end else begin
            $display("FAIL sync_pattern_detector");
        end
        $finish;
    end

endmodule
